// ----- rtl/cdd_pkg.sv -----
// ----------------------------------------------------------------------------
// cdd_pkg
// Shared codes and field widths for the cumulative dictionary decoder.
// ----------------------------------------------------------------------------
package cdd_pkg;

	// Fixed field widths of the item and result beats
	localparam int OP_W     = 2;
	localparam int VALUE_W  = 32;
	localparam int OFFSET_W = 12;
	localparam int STATUS_W = 2;

	// Operation codes; the fourth code is unused and ignored
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

// ----- rtl/cumulative_dictionary_decoder_top.sv -----
// ----------------------------------------------------------------------------
// cumulative_dictionary_decoder_top
// Decodes dictionary-coded column items against a dictionary that grows
// across pages: clear, append a value token, or look up a row offset.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-------------------------------
//  item    | in        | item_valid / item_stall     | operation, entry_value, row_offset
//  result  | out       | result_valid / result_stall | decoded_value, status
//
// One item per cycle while item_stall is low: each item makes at most a single
// access to the dictionary memory (one write port, one read port, registered read data).
// A result passes through the memory read stage, then the output register.
// Clear gives no result; append gives one only when the store is full.
// Reset clears the entry count and the pipeline valids; memory contents are
// left as they are. A stalled result holds item_stall only once the read
// stage also holds a result.

module cumulative_dictionary_decoder_top #(
	parameter int DICT_DEPTH  = 4096,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [cdd_pkg::OP_W-1:0]      operation,
	input  logic [cdd_pkg::VALUE_W-1:0]   entry_value,
	input  logic [cdd_pkg::OFFSET_W-1:0]  row_offset,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [cdd_pkg::VALUE_W-1:0]   decoded_value,
	output logic [cdd_pkg::STATUS_W-1:0]  status
);

	import cdd_pkg::*;

	localparam int ADDR_W = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
	localparam int CNT_W  = $clog2(DICT_DEPTH + 1);
	localparam int CMP_W  = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;
	localparam int WIDE_W = (VALUE_WIDTH > VALUE_W) ? VALUE_WIDTH : VALUE_W;

	// Dictionary memory and entry count
	logic [VALUE_WIDTH-1:0] dict_mem [DICT_DEPTH];
	logic [CNT_W-1:0]       entry_count_q;

	// Read stage
	logic                   valid_s1;
	logic                   hit_s1;
	status_t                status_s1;
	logic [VALUE_WIDTH-1:0] rd_data_s1;

	// Output register
	logic                   result_valid_q;
	logic [VALUE_W-1:0]     decoded_q;
	status_t                status_q;

	logic                   accept;
	logic                   out_free;
	logic                   adv_s1;
	logic                   is_append;
	logic                   is_lookup;
	logic                   is_clear;
	logic                   dict_full;
	logic                   in_range;
	logic                   gen_result;
	logic                   wr_en;
	logic                   rd_en;
	logic [CMP_W-1:0]       offset_ext;
	logic [CMP_W-1:0]       count_ext;
	logic [ADDR_W-1:0]      rd_addr;
	logic [ADDR_W-1:0]      wr_addr;
	logic [WIDE_W-1:0]      entry_wide;
	logic [WIDE_W-1:0]      rd_wide;
	logic [VALUE_WIDTH-1:0] store_data;

	// Decode the item beat
	assign accept     = item_valid && !item_stall;
	assign is_clear   = (operation == OP_CLEAR);
	assign is_append  = (operation == OP_APPEND);
	assign is_lookup  = (operation == OP_LOOKUP);
	assign dict_full  = (entry_count_q == CNT_W'(DICT_DEPTH));
	assign offset_ext = CMP_W'(row_offset);
	assign count_ext  = CMP_W'(entry_count_q);
	assign in_range   = (offset_ext < count_ext);
	assign gen_result = accept && (is_lookup || (is_append && dict_full));
	assign wr_en      = accept && is_append && !dict_full;
	assign rd_en      = accept && is_lookup && in_range;
	assign rd_addr    = offset_ext[ADDR_W-1:0];
	assign wr_addr    = count_ext[ADDR_W-1:0];
	assign entry_wide = WIDE_W'(entry_value);
	assign store_data = entry_wide[VALUE_WIDTH-1:0];
	assign rd_wide    = WIDE_W'(rd_data_s1);

	// Advance the pipeline when the output register can take a beat
	assign out_free   = !result_valid_q || !result_stall;
	assign adv_s1     = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	// Write and read the dictionary memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			dict_mem[wr_addr] <= store_data;
		end
		if (rd_en) begin
			rd_data_s1 <= dict_mem[rd_addr];
		end
	end

	// Track the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (accept && is_clear) begin
			entry_count_q <= '0;
		end else if (wr_en) begin
			entry_count_q <= entry_count_q + CNT_W'(1);
		end
	end

	// Hold the pending result in the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (gen_result) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_result) begin
			hit_s1 <= rd_en;
			priority if (is_append) begin
				status_s1 <= ST_FULL;
			end else if (in_range) begin
				status_s1 <= ST_OK;
			end else begin
				status_s1 <= ST_RANGE;
			end
		end
	end

	// Load the output register, drop the beat once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			decoded_q <= hit_s1 ? rd_wide[VALUE_W-1:0] : '0;
			status_q  <= status_s1;
		end
	end

	assign result_valid  = result_valid_q;
	assign decoded_value = decoded_q;
	assign status        = status_q;

	// Checks on the decoder's own logic
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CNT_W'(DICT_DEPTH))
		else $error("entry count beyond dictionary depth");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_OK) |-> decoded_value == '0)
		else $error("error result carries a nonzero value");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_append && dict_full |=> valid_s1 && status_s1 == ST_FULL)
		else $error("append into full store not flagged");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_clear |=> entry_count_q == '0)
		else $error("clear did not empty the dictionary");

endmodule
